[design/ipv4fhg_pkg.sv]
package ipv4fhg_pkg;

    // Header constants and limits.
    localparam logic [14:0] MAX_SEGMENT = 15'd16384;
    localparam logic [4:0]  MAX_RESULTS = 5'd30;
    localparam logic [13:0] MTU_MIN     = 14'd576;
    localparam logic [13:0] MTU_MAX     = 14'd9000;
    localparam logic [13:0] MTU_RESET   = 14'd1500;
    localparam logic [13:0] HDR_BYTES   = 14'd20;
    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  TTL_VALUE   = 8'd128;
    localparam logic [15:0] FLAG_DF     = 16'h4000;
    localparam logic [15:0] FLAG_MF     = 16'h2000;
    localparam logic [15:0] WORD_MASK   = 16'hFFFF;

    typedef enum logic [1:0] {
        CFG_SRC_ADDR  = 2'd0,
        CFG_DST_ADDR  = 2'd1,
        CFG_LINK_MTU  = 2'd2,
        CFG_DONT_FRAG = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DECIDE,
        S_EMIT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic [14:0] segment_length;
        logic [7:0]  upper_protocol;
    } t_in_item;

    typedef struct packed {
        logic [13:0] total_length;
        logic [15:0] flags_offset;
        logic [15:0] identification;
        logic [15:0] header_checksum;
        logic [14:0] payload_offset;
        logic [13:0] payload_length;
        logic        last;
        logic        error;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic bump_id;
        logic start;
        logic emit_frag;
        logic emit_err;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_zero;
        logic len_over;
        logic fits;
        logic frag_err;
        logic final_frag;
        logic slot_free;
    } t_dp_stat;

endpackage

[design/ipv4fhg_ctrl.sv]
module ipv4fhg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  ipv4fhg_pkg::t_dp_stat i_stat,
    output ipv4fhg_pkg::t_ctl_cmd o_cmd,
    output logic                  o_in_stall
);

    ipv4fhg_pkg::t_state r_state;
    ipv4fhg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv4fhg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipv4fhg_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ipv4fhg_pkg::S_PREP;
                end
            end
            ipv4fhg_pkg::S_PREP: begin
                if (i_stat.len_zero) begin
                    n_state = ipv4fhg_pkg::S_IDLE;
                end else if (i_stat.len_over) begin
                    n_state = ipv4fhg_pkg::S_ERR;
                end else begin
                    n_state = ipv4fhg_pkg::S_DECIDE;
                end
            end
            ipv4fhg_pkg::S_DECIDE: begin
                if (!i_stat.fits && i_stat.frag_err) begin
                    n_state = ipv4fhg_pkg::S_ERR;
                end else begin
                    n_state = ipv4fhg_pkg::S_EMIT;
                end
            end
            ipv4fhg_pkg::S_EMIT: begin
                if (i_stat.slot_free && i_stat.final_frag) begin
                    n_state = ipv4fhg_pkg::S_IDLE;
                end
            end
            ipv4fhg_pkg::S_ERR: begin
                if (i_stat.slot_free) begin
                    n_state = ipv4fhg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ipv4fhg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ipv4fhg_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_item = i_in_valid;
            end
            ipv4fhg_pkg::S_PREP: begin
                o_cmd.bump_id = !i_stat.len_zero && !i_stat.len_over;
            end
            ipv4fhg_pkg::S_DECIDE: begin
                o_cmd.start = 1'b1;
            end
            ipv4fhg_pkg::S_EMIT: begin
                o_cmd.emit_frag = i_stat.slot_free;
            end
            ipv4fhg_pkg::S_ERR: begin
                o_cmd.emit_err = i_stat.slot_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

[design/ipv4fhg_dpath.sv]
module ipv4fhg_dpath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    input  ipv4fhg_pkg::t_in_item  i_in_data,
    input  logic                   i_out_stall,
    input  ipv4fhg_pkg::t_ctl_cmd  i_cmd,
    output ipv4fhg_pkg::t_dp_stat  o_stat,
    output logic                   o_out_valid,
    output ipv4fhg_pkg::t_out_item o_out_data
);

    // Configuration registers.
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic [13:0] r_mtu;
    logic        r_df;

    // Values derived from the configuration, refreshed every cycle.
    logic [13:0] r_room;
    logic [13:0] r_frag;
    logic [18:0] r_addr_sum;

    // Per-segment working registers.
    logic [14:0] r_len;
    logic [7:0]  r_proto;
    logic [15:0] r_ident;
    logic [18:0] r_base;
    logic [14:0] r_pos;
    logic [14:0] r_rem;
    logic        r_whole;

    logic                   r_out_valid;
    ipv4fhg_pkg::t_out_item r_out;

    logic [13:0] mtu_clamped;
    logic [19:0] len_limit;
    logic [18:0] base_sum;
    logic        final_frag;
    logic [13:0] plen;
    logic [15:0] fo;
    logic [13:0] tlen;
    logic [20:0] csum_raw;
    logic [16:0] csum_fold1;
    logic [16:0] csum_fold2;
    logic        slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= '0;
            r_dst <= '0;
            r_mtu <= ipv4fhg_pkg::MTU_RESET;
            r_df  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (ipv4fhg_pkg::t_cfg_reg'(i_cfg_index))
                ipv4fhg_pkg::CFG_SRC_ADDR:  r_src <= i_cfg_data;
                ipv4fhg_pkg::CFG_DST_ADDR:  r_dst <= i_cfg_data;
                ipv4fhg_pkg::CFG_LINK_MTU:  r_mtu <= i_cfg_data[13:0];
                ipv4fhg_pkg::CFG_DONT_FRAG: r_df  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_mtu < ipv4fhg_pkg::MTU_MIN) begin
            mtu_clamped = ipv4fhg_pkg::MTU_MIN;
        end else if (r_mtu > ipv4fhg_pkg::MTU_MAX) begin
            mtu_clamped = ipv4fhg_pkg::MTU_MAX;
        end else begin
            mtu_clamped = r_mtu;
        end
    end

    always_ff @(posedge i_clk) begin
        r_room     <= mtu_clamped - ipv4fhg_pkg::HDR_BYTES;
        r_frag     <= (mtu_clamped - ipv4fhg_pkg::HDR_BYTES) & ~14'd7;
        r_addr_sum <= 19'(r_src[31:16]) + 19'(r_src[15:0])
                    + 19'(r_dst[31:16]) + 19'(r_dst[15:0])
                    + 19'({ipv4fhg_pkg::VER_IHL, 8'h00});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident <= '0;
        end else if (i_cmd.bump_id) begin
            r_ident <= r_ident + 16'd1;
        end
    end

    assign len_limit = 20'(r_frag) * 20'(ipv4fhg_pkg::MAX_RESULTS);
    assign base_sum  = 19'(r_addr_sum) + 19'({ipv4fhg_pkg::TTL_VALUE, r_proto})
                     + 19'(r_ident);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_len   <= i_in_data.segment_length;
            r_proto <= i_in_data.upper_protocol;
        end
        if (i_cmd.start) begin
            r_pos   <= '0;
            r_rem   <= r_len;
            r_whole <= o_stat.fits;
            r_base  <= base_sum;
        end else if (i_cmd.emit_frag) begin
            r_pos <= r_pos + 15'(r_frag);
            r_rem <= r_rem - 15'(r_frag);
        end
    end

    // Fields of the fragment that the current position describes.
    assign final_frag = r_whole || (r_rem <= 15'(r_frag));
    assign plen       = final_frag ? r_rem[13:0] : r_frag;
    assign tlen       = plen + ipv4fhg_pkg::HDR_BYTES;

    always_comb begin
        if (!final_frag) begin
            fo = ipv4fhg_pkg::FLAG_MF;
        end else if (r_whole && r_df) begin
            fo = ipv4fhg_pkg::FLAG_DF;
        end else begin
            fo = '0;
        end
        fo = fo | 16'(r_pos[14:3]);
    end

    // End-around carry fold; two passes cover every possible carry.
    assign csum_raw   = 21'(r_base) + 21'(tlen) + 21'(fo);
    assign csum_fold1 = 17'(csum_raw[15:0]) + 17'(csum_raw[20:16]);
    assign csum_fold2 = 17'(csum_fold1[15:0]) + 17'(csum_fold1[16]);

    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_frag || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_frag) begin
            r_out.total_length    <= tlen;
            r_out.flags_offset    <= fo;
            r_out.identification  <= r_ident;
            r_out.header_checksum <= ~csum_fold2[15:0] & ipv4fhg_pkg::WORD_MASK;
            r_out.payload_offset  <= r_pos;
            r_out.payload_length  <= plen;
            r_out.last            <= final_frag;
            r_out.error           <= 1'b0;
        end else if (i_cmd.emit_err) begin
            r_out.total_length    <= '0;
            r_out.flags_offset    <= '0;
            r_out.identification  <= '0;
            r_out.header_checksum <= '0;
            r_out.payload_offset  <= '0;
            r_out.payload_length  <= '0;
            r_out.last            <= 1'b1;
            r_out.error           <= 1'b1;
        end
    end

    assign o_stat.len_zero   = (r_len == '0);
    assign o_stat.len_over   = (r_len > ipv4fhg_pkg::MAX_SEGMENT);
    assign o_stat.fits       = (r_len <= 15'(r_room));
    assign o_stat.frag_err   = r_df || (20'(r_len) > len_limit);
    assign o_stat.final_frag = final_frag;
    assign o_stat.slot_free  = slot_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/ipv4_fragment_header_generator.sv]
// IPv4 fragment header generator. Each input transfer names an upper-layer
// segment (length and protocol number); the block answers with one header
// descriptor per fragment, or with a single error descriptor when the segment
// is longer than 16384 bytes, needs fragmenting while dont_fragment is set, or
// would need more than 30 fragments. A zero-length segment produces nothing.
// Descriptors carry version 4, IHL 5, TTL 128, the configured addresses folded
// into the one's-complement header checksum, and a 16-bit identification that
// is incremented before use (first datagram gets 1). The MTU register is
// clamped to 576..9000. Segments are handled one at a time: an input transfer
// is taken in the idle state, setup follows (S_PREP: length checks and
// identification update, then S_DECIDE: fragment decision and checksum base),
// and then one descriptor leaves per cycle while the output is not stalled.
// The descriptor output is registered, so the last descriptor of one segment
// may wait for its transfer while the next segment is already accepted.
// Configuration writes are always ready and must only be issued while no
// segment is in flight.
module ipv4_fragment_header_generator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data,

    // Segment input channel.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ipv4fhg_pkg::t_in_item  i_in_data,

    // Descriptor output channel.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ipv4fhg_pkg::t_out_item o_out_data
);

    ipv4fhg_pkg::t_ctl_cmd cmd;
    ipv4fhg_pkg::t_dp_stat stat;

    // Register writes need no wait state.
    assign o_cfg_ready = 1'b1;

    ipv4fhg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ipv4fhg_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // A segment is worked on alone: the input closes right after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted a second segment while busy");

    // An error descriptor is always the last one and carries no header.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error) |->
        (o_out_data.last && o_out_data.total_length == '0
         && o_out_data.header_checksum == '0))
        else $error("malformed error descriptor");

    // A normal descriptor has total length equal to header plus payload.
    a_length_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.error) |->
        (o_out_data.total_length
         == o_out_data.payload_length + ipv4fhg_pkg::HDR_BYTES))
        else $error("total length does not match payload length");
`endif

endmodule
